FILE: rtl/sawfr_pkg.sv
// ---------------------------------------------------------------------------
// Stop-and-wait frame receiver package
// Types, codes and constants shared by the receiver modules.
// ---------------------------------------------------------------------------
package sawfr_pkg;

  localparam logic [7:0] FLAG_BYTE   = 8'h7e;
  localparam logic [7:0] ESC_BYTE    = 8'h7d;
  localparam logic [7:0] ESC_XOR     = 8'h20;
  localparam int unsigned SEQ_BIT_IN = 6;
  localparam logic [2:0] POS_MAX     = 3'd5;
  localparam logic [2:0] POS_MIN_OK  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_READY   = 2'd1;
  localparam logic [1:0] CFG_REJECT  = 2'd2;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // End-of-frame status codes.
  localparam logic [1:0] ST_ACCEPTED  = 2'd0;
  localparam logic [1:0] ST_DUPLICATE = 2'd1;
  localparam logic [1:0] ST_DATA_ERR  = 2'd2;
  localparam logic [1:0] ST_MALFORMED = 2'd3;

  typedef struct packed {
    logic [7:0] address_byte;
    logic [6:0] ready_code;
    logic [6:0] reject_code;
  } cfg_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] data_byte;
    logic [1:0] frame_status;
    logic       response_valid;
    logic [7:0] response_ctrl;
  } result_t;

endpackage

FILE: rtl/sawfr_intf.sv
// ---------------------------------------------------------------------------
// Stop-and-wait frame receiver channels
// Valid/ready channels for line bytes, results and configuration writes.
// ---------------------------------------------------------------------------
interface sawfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sawfr_res_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] data_byte;
  logic [1:0] frame_status;
  logic       response_valid;
  logic [7:0] response_ctrl;

  modport source (output valid, output out_kind, output data_byte, output frame_status,
                  output response_valid, output response_ctrl, input ready);
  modport sink (input valid, input out_kind, input data_byte, input frame_status,
                input response_valid, input response_ctrl, output ready);
endinterface

interface sawfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_index;
  logic [7:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: rtl/sawfr_cfg_regs.sv
// ---------------------------------------------------------------------------
// Configuration register bank
// Holds the expected address and the low bits of the RR and REJ replies.
// ---------------------------------------------------------------------------
module sawfr_cfg_regs import sawfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  logic [1:0] wr_index_i,
  input  logic [7:0] wr_data_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        CFG_ADDRESS: cfg_d.address_byte = wr_data_i;
        CFG_READY:   cfg_d.ready_code   = wr_data_i[6:0];
        CFG_REJECT:  cfg_d.reject_code  = wr_data_i[6:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.address_byte <= 8'd3;
      cfg_q.ready_code   <= 7'd5;
      cfg_q.reject_code  <= 7'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/sawfr_deframe.sv
// ---------------------------------------------------------------------------
// Frame decoder
// Flag hunting, destuffing, header, sequence and data checks for one byte a cycle when accepted.
// ---------------------------------------------------------------------------
module sawfr_deframe import sawfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  input  cfg_t       cfg_i,
  output logic       push_o,
  output result_t    result_o
);

  logic       in_frame_q, in_frame_d;
  logic       esc_pend_q, esc_pend_d;
  logic [2:0] pos_q, pos_d;
  logic [7:0] seen_addr_q, seen_addr_d;
  logic [7:0] seen_ctrl_q, seen_ctrl_d;
  logic [7:0] held_q, held_d;
  logic [7:0] check_q, check_d;
  logic       hdr_bad_q, hdr_bad_d;
  logic       exp_seq_q, exp_seq_d;

  logic       is_flag;
  logic       take;
  logic [7:0] tbyte;

  assign is_flag = (rx_byte_i == FLAG_BYTE);

  always_comb begin
    in_frame_d  = in_frame_q;
    esc_pend_d  = esc_pend_q;
    pos_d       = pos_q;
    seen_addr_d = seen_addr_q;
    seen_ctrl_d = seen_ctrl_q;
    held_d      = held_q;
    check_d     = check_q;
    hdr_bad_d   = hdr_bad_q;
    exp_seq_d   = exp_seq_q;
    push_o      = 1'b0;
    result_o    = '0;
    take        = 1'b0;
    tbyte       = rx_byte_i;

    if (accept_i) begin
      if (!in_frame_q) begin
        if (is_flag) begin
          in_frame_d  = 1'b1;
          esc_pend_d  = 1'b0;
          pos_d       = '0;
          seen_addr_d = '0;
          seen_ctrl_d = '0;
          held_d      = '0;
          check_d     = '0;
          hdr_bad_d   = 1'b0;
        end
      end else if (is_flag) begin
        if (pos_q != '0 || esc_pend_q) begin
          push_o            = 1'b1;
          result_o.out_kind = KIND_STATUS;
          if (esc_pend_q || pos_q < POS_MIN_OK || hdr_bad_q) begin
            result_o.frame_status = ST_MALFORMED;
          end else if (seen_ctrl_q[SEQ_BIT_IN] != exp_seq_q) begin
            result_o.frame_status   = ST_DUPLICATE;
            result_o.response_valid = 1'b1;
            result_o.response_ctrl  = {exp_seq_q, cfg_i.ready_code};
          end else if (held_q != check_q) begin
            result_o.frame_status   = ST_DATA_ERR;
            result_o.response_valid = 1'b1;
            result_o.response_ctrl  = {exp_seq_q, cfg_i.reject_code};
          end else begin
            exp_seq_d               = ~exp_seq_q;
            result_o.frame_status   = ST_ACCEPTED;
            result_o.response_valid = 1'b1;
            result_o.response_ctrl  = {~exp_seq_q, cfg_i.ready_code};
          end
          in_frame_d = 1'b0;
          esc_pend_d = 1'b0;
        end
      end else if (esc_pend_q) begin
        esc_pend_d = 1'b0;
        take       = 1'b1;
        tbyte      = rx_byte_i ^ ESC_XOR;
      end else if (rx_byte_i == ESC_BYTE) begin
        esc_pend_d = 1'b1;
      end else begin
        take = 1'b1;
      end
    end

    if (take) begin
      case (pos_q)
        3'd0: begin
          seen_addr_d = tbyte;
          if (tbyte != cfg_i.address_byte) hdr_bad_d = 1'b1;
        end
        3'd1: seen_ctrl_d = tbyte;
        3'd2: begin
          if (tbyte != (seen_addr_q ^ seen_ctrl_q)) hdr_bad_d = 1'b1;
        end
        3'd3: held_d = tbyte;
        default: begin
          push_o             = 1'b1;
          result_o.out_kind  = KIND_PAYLOAD;
          result_o.data_byte = held_q;
          check_d            = check_q ^ held_q;
          held_d             = tbyte;
        end
      endcase
      if (pos_q < POS_MAX) pos_d = pos_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      esc_pend_q  <= 1'b0;
      pos_q       <= '0;
      seen_addr_q <= '0;
      seen_ctrl_q <= '0;
      held_q      <= '0;
      check_q     <= '0;
      hdr_bad_q   <= 1'b0;
      exp_seq_q   <= 1'b0;
    end else begin
      in_frame_q  <= in_frame_d;
      esc_pend_q  <= esc_pend_d;
      pos_q       <= pos_d;
      seen_addr_q <= seen_addr_d;
      seen_ctrl_q <= seen_ctrl_d;
      held_q      <= held_d;
      check_q     <= check_d;
      hdr_bad_q   <= hdr_bad_d;
      exp_seq_q   <= exp_seq_d;
    end
  end

  // The position counter saturates and never runs past its limit.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_MAX) else $error("byte position out of range");

  // A status result always ends the frame.
  a_status_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && result_o.out_kind == KIND_STATUS) |=> !in_frame_q)
    else $error("frame still open after status");

  // The expected sequence bit flips exactly when a frame is accepted.
  a_seq_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && result_o.out_kind == KIND_STATUS &&
     result_o.frame_status == ST_ACCEPTED) |=> !$stable(exp_seq_q))
    else $error("expected sequence did not toggle");

  a_seq_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_o && result_o.out_kind == KIND_STATUS &&
      result_o.frame_status == ST_ACCEPTED) |=> $stable(exp_seq_q))
    else $error("expected sequence changed without an accepted frame");

endmodule

FILE: rtl/sawfr_out_fifo.sv
// ---------------------------------------------------------------------------
// Result queue
// Two-entry queue that decouples the decoder from the result consumer.
// ---------------------------------------------------------------------------
module sawfr_out_fifo import sawfr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    not_full_o,
  output logic    valid_o,
  input  logic    pop_ready_i,
  output result_t data_o
);

  result_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  assign valid_o    = (count_q != 2'd0);
  assign not_full_o = (count_q != 2'd2);
  assign pop        = valid_o && pop_ready_i;
  assign data_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: rtl/stop_and_wait_frame_receiver.sv
// ---------------------------------------------------------------------------
// Stop-and-wait frame receiver
// Byte-stuffed frame receiver with header, data and sequence checks.
// ---------------------------------------------------------------------------
// The receiver takes one raw line byte per transfer on rx_i and accepts a
// new byte in every clock cycle as long as its two-entry result queue has
// room. Each byte is decoded combinationally against the frame state, and
// any result it causes (a destuffed payload byte, released one byte late,
// or an end-of-frame status with the RR/REJ reply byte) is registered in
// the queue and presented on res_o in order. With res_o.ready held high the
// sustained rate is one byte per cycle; the queue depth sets how many
// results may wait before rx_i.ready drops. Configuration registers on cfg_i
// should only change while the receiver is idle.
// ---------------------------------------------------------------------------
module stop_and_wait_frame_receiver import sawfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sawfr_rx_if.sink    rx_i,
  sawfr_res_if.source res_o,
  sawfr_cfg_if.sink   cfg_i
);

  cfg_t    cfg;
  logic    accept;
  logic    push;
  result_t result;
  result_t head;
  logic    not_full;

  // Register writes are always taken; cfg_i.ready is tied high.
  assign cfg_i.ready = 1'b1;

  sawfr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.reg_index),
    .wr_data_i  (cfg_i.wdata),
    .cfg_o      (cfg)
  );

  // A byte transfer completes whenever the queue can absorb a result.
  assign rx_i.ready = not_full;
  assign accept     = rx_i.valid && not_full;

  sawfr_deframe u_deframe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_i.rx_byte),
    .cfg_i     (cfg),
    .push_o    (push),
    .result_o  (result)
  );

  sawfr_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (result),
    .not_full_o  (not_full),
    .valid_o     (res_o.valid),
    .pop_ready_i (res_o.ready),
    .data_o      (head)
  );

  assign res_o.out_kind       = head.out_kind;
  assign res_o.data_byte      = head.data_byte;
  assign res_o.frame_status   = head.frame_status;
  assign res_o.response_valid = head.response_valid;
  assign res_o.response_ctrl  = head.response_ctrl;

endmodule
